[rtl/lppc_pkg.sv]
// Package for the LED pattern and playback control unit.
// Holds the request and command codes, the register map, reset values,
// the shared structs and the animation sequence tables. No dependencies.
package lppc_pkg;

  // Request kinds carried by one item
  typedef enum logic [1:0] {
    REQ_COMMAND = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_SAMPLE  = 2'd2
  } req_type_t;

  // ASCII command codes
  localparam logic [7:0] CMD_PATTERN_FIRST = 8'h55;  // 'U'
  localparam logic [7:0] CMD_PATTERN_LAST  = 8'h5A;  // 'Z'
  localparam logic [7:0] CMD_SPEED_FIRST   = 8'h31;  // '1'
  localparam logic [7:0] CMD_SPEED_LAST    = 8'h33;  // '3'
  localparam logic [7:0] CMD_PLAY          = 8'h42;  // 'B'
  localparam logic [7:0] CMD_PAUSE         = 8'h43;  // 'C'

  // Register map: index is paddr[3:2]
  localparam int          PADDR_WIDTH     = 4;
  localparam int          PDATA_WIDTH     = 32;
  localparam logic [1:0]  REG_SPEED_ONE   = 2'd0;
  localparam logic [1:0]  REG_SPEED_TWO   = 2'd1;
  localparam logic [1:0]  REG_SPEED_THREE = 2'd2;

  localparam logic [7:0]  SPEED_ONE_RESET   = 8'd20;
  localparam logic [7:0]  SPEED_TWO_RESET   = 8'd10;
  localparam logic [7:0]  SPEED_THREE_RESET = 8'd5;

  // Speed selections
  localparam logic [1:0]  SPEED_ONE   = 2'd0;
  localparam logic [1:0]  SPEED_TWO   = 2'd1;

  // DAC midscale value asked for on a pause (driven by the DAC side)
  localparam logic [7:0]  DAC_MIDSCALE = 8'h80;

  localparam int          BUFFER_DEPTH_DEFAULT = 512;

  typedef struct packed {
    logic [7:0] speed_one;
    logic [7:0] speed_two;
    logic [7:0] speed_three;
  } hold_cfg_t;

  // Fixed-width part of one result item
  typedef struct packed {
    logic [15:0] frame_bits;
    logic        frame_valid;
    logic        sample_valid;
    logic        refill_request;
    logic        refill_half;
    logic        playing_now;
    logic        midscale_write;
  } result_t;

  // Length of each animation sequence
  function automatic logic [3:0] seq_len(input logic [2:0] pat);
    logic [3:0] len;
    case (pat)
      3'd0:    len = 4'd2;
      3'd1:    len = 4'd6;
      3'd2:    len = 4'd6;
      3'd3:    len = 4'd2;
      3'd4:    len = 4'd8;
      3'd5:    len = 4'd4;
      default: len = 4'd2;
    endcase
    return len;
  endfunction

  // Frame pattern of a sequence at a position
  function automatic logic [15:0] seq_frame(input logic [2:0] pat, input logic [2:0] pos);
    logic [15:0] f;
    f = 16'h0000;
    case (pat)
      3'd1: begin
        case (pos)
          3'd0:    f = 16'hF000;
          3'd1:    f = 16'h0F00;
          3'd2:    f = 16'h00F0;
          3'd3:    f = 16'h000F;
          3'd4:    f = 16'h00F0;
          3'd5:    f = 16'h0F00;
          default: f = 16'h0000;
        endcase
      end
      3'd2: begin
        case (pos)
          3'd0:    f = 16'h8888;
          3'd1:    f = 16'h4444;
          3'd2:    f = 16'h2222;
          3'd3:    f = 16'h1111;
          3'd4:    f = 16'h2222;
          3'd5:    f = 16'h4444;
          default: f = 16'h0000;
        endcase
      end
      3'd3: begin
        case (pos)
          3'd0:    f = 16'hAAAA;
          3'd1:    f = 16'h5555;
          default: f = 16'h0000;
        endcase
      end
      3'd4: begin
        case (pos)
          3'd0:    f = 16'h0000;
          3'd1:    f = 16'hF000;
          3'd2:    f = 16'hFF00;
          3'd3:    f = 16'hFFF0;
          3'd4:    f = 16'hFFFF;
          3'd5:    f = 16'h0FFF;
          3'd6:    f = 16'h00FF;
          default: f = 16'h000F;
        endcase
      end
      3'd5: begin
        case (pos)
          3'd0:    f = 16'h0660;
          3'd1:    f = 16'h0FF0;
          3'd2:    f = 16'hFFFF;
          3'd3:    f = 16'h0FF0;
          default: f = 16'h0000;
        endcase
      end
      default: begin
        case (pos)
          3'd1:    f = 16'hFFFF;
          default: f = 16'h0000;
        endcase
      end
    endcase
    return f;
  endfunction

endpackage

[rtl/led_pattern_and_playback_control_unit.sv]
// Top level of the LED pattern and playback control unit.
// Input register, per-item engine, result register and APB register block;
// uses lppc_pkg, lppc_regs and lppc_engine.
//
// Each item is a command byte, a display refresh tick or an audio sample tick,
// and each gives exactly one result item. An item is registered on acceptance,
// worked by the engine against the current state once the result register is
// free, and its result is registered in the output register, which drives the
// outputs and holds the result until it is taken. One item is taken per cycle
// while the result side keeps taking results; the throughput is set by the
// single state update the engine does per cycle. A result that waits under
// result_stall holds the engine and then the input register, so item_stall
// rises only when both are full.
// Commands 'U'..'Z' pick an animation, '1'..'3' a frame-hold speed, 'B' starts
// playback and 'C' pauses it, raising midscale_write so the DAC is parked at
// 0x80. The three hold registers sit at byte addresses 0, 4 and 8; write them
// only while no item is in flight. sample_index is $clog2(BUFFER_DEPTH) bits.
module led_pattern_and_playback_control_unit #(
  parameter int BUFFER_DEPTH = lppc_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       req_type,
  input  logic [7:0]                       command_byte,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [15:0]                      frame_bits,
  output logic                             frame_valid,
  output logic [$clog2(BUFFER_DEPTH)-1:0]  sample_index,
  output logic                             sample_valid,
  output logic                             refill_request,
  output logic                             refill_half,
  output logic                             playing_now,
  output logic                             midscale_write,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lppc_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [lppc_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [lppc_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                             pready
);
  import lppc_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);

  hold_cfg_t     holds;
  result_t       eng_result;
  logic [IW-1:0] eng_sample_index;

  // input register
  logic          s1_valid;
  req_type_t     s1_req;
  logic [7:0]    s1_cmd;

  // result register
  result_t       out_result;
  logic [IW-1:0] out_sample_index;

  logic          out_free;
  logic          fire;
  logic          accept;

  assign pready = 1'b1;

  // The result register frees when empty or taken this cycle
  assign out_free   = !result_valid || !result_stall;
  assign fire       = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  // hold the payload of a stalled item; load on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req_type_t'(req_type);
      s1_cmd <= command_byte;
    end
  end

  lppc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .holds   (holds)
  );

  lppc_engine #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .req_type     (s1_req),
    .command_byte (s1_cmd),
    .holds        (holds),
    .result       (eng_result),
    .sample_index (eng_sample_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result       <= eng_result;
      out_sample_index <= eng_sample_index;
    end
  end

  assign frame_bits     = out_result.frame_bits;
  assign frame_valid    = out_result.frame_valid;
  assign sample_index   = out_sample_index;
  assign sample_valid   = out_result.sample_valid;
  assign refill_request = out_result.refill_request;
  assign refill_half    = out_result.refill_half;
  assign playing_now    = out_result.playing_now;
  assign midscale_write = out_result.midscale_write;

  // A result never carries both a frame and a sample
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(frame_valid && sample_valid))
    else $error("result carries both a frame and a sample");

  // A pause that asks for midscale leaves playback stopped
  a_mid_paused: assert property (@(posedge clk) disable iff (rst)
    (result_valid && midscale_write) |-> !playing_now)
    else $error("midscale write while still playing");

  // Refills only come with a sample sent while playing
  a_refill_sample: assert property (@(posedge clk) disable iff (rst)
    (result_valid && refill_request) |-> (sample_valid && playing_now))
    else $error("refill request without a sample");

  // An engine result is never dropped: a stalled result register holds
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(out_result)))
    else $error("stalled result changed");

endmodule

[rtl/lppc_regs.sv]
// Configuration registers of the LED pattern and playback control unit.
// APB-style write and read of the three frame-hold registers; uses lppc_pkg.
module lppc_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lppc_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [lppc_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [lppc_pkg::PDATA_WIDTH-1:0] prdata,
  output lppc_pkg::hold_cfg_t              holds
);
  import lppc_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      holds.speed_one   <= SPEED_ONE_RESET;
      holds.speed_two   <= SPEED_TWO_RESET;
      holds.speed_three <= SPEED_THREE_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_SPEED_ONE:   holds.speed_one   <= pwdata[7:0];
        REG_SPEED_TWO:   holds.speed_two   <= pwdata[7:0];
        REG_SPEED_THREE: holds.speed_three <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SPEED_ONE:   prdata = {{(PDATA_WIDTH-8){1'b0}}, holds.speed_one};
      REG_SPEED_TWO:   prdata = {{(PDATA_WIDTH-8){1'b0}}, holds.speed_two};
      REG_SPEED_THREE: prdata = {{(PDATA_WIDTH-8){1'b0}}, holds.speed_three};
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/lppc_engine.sv]
// Per-item engine of the LED pattern and playback control unit.
// Holds the animation and playback state and forms one result per item;
// uses lppc_pkg.
module lppc_engine #(
  parameter int BUFFER_DEPTH = lppc_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  lppc_pkg::req_type_t             req_type,
  input  logic [7:0]                      command_byte,
  input  lppc_pkg::hold_cfg_t             holds,
  output lppc_pkg::result_t               result,
  output logic [$clog2(BUFFER_DEPTH)-1:0] sample_index
);
  import lppc_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW:0] HALF_MARK = (IW+1)'(BUFFER_DEPTH / 2);
  localparam logic [IW:0] FULL_MARK = (IW+1)'(BUFFER_DEPTH);

  logic [2:0]    pattern_select, pattern_select_next;
  logic [1:0]    speed_select, speed_select_next;
  logic [7:0]    hold_count, hold_count_next;
  logic [2:0]    frame_position, frame_position_next;
  logic          play_flag, play_flag_next;
  logic [IW-1:0] buffer_position, buffer_position_next;

  logic [7:0]    cmd_off;
  logic [2:0]    new_pattern;
  logic [3:0]    cur_len;
  logic [2:0]    pos;
  logic [3:0]    pos_plus;
  logic [7:0]    hold;
  logic [7:0]    hc_inc;
  logic [IW:0]   buf_plus;

  always_comb begin
    cmd_off     = command_byte - CMD_PATTERN_FIRST;
    new_pattern = cmd_off[2:0];
    cur_len     = seq_len(pattern_select);
    pos         = ({1'b0, frame_position} < cur_len) ? frame_position : 3'd0;
    pos_plus    = {1'b0, pos} + 4'd1;
    hc_inc      = (hold_count == 8'hFF) ? 8'hFF : hold_count + 8'd1;
    buf_plus    = {1'b0, buffer_position} + (IW+1)'(1);
    case (speed_select)
      SPEED_ONE: hold = holds.speed_one;
      SPEED_TWO: hold = holds.speed_two;
      default:   hold = holds.speed_three;
    endcase
  end

  always_comb begin
    pattern_select_next  = pattern_select;
    speed_select_next    = speed_select;
    hold_count_next      = hold_count;
    frame_position_next  = frame_position;
    play_flag_next       = play_flag;
    buffer_position_next = buffer_position;
    result               = '0;
    sample_index         = '0;

    case (req_type)
      REQ_COMMAND: begin
        if (command_byte >= CMD_PATTERN_FIRST && command_byte <= CMD_PATTERN_LAST) begin
          pattern_select_next = new_pattern;
          // drop a position that the new sequence does not reach
          if ({1'b0, frame_position} >= seq_len(new_pattern)) begin
            frame_position_next = 3'd0;
          end
        end else if (command_byte >= CMD_SPEED_FIRST && command_byte <= CMD_SPEED_LAST) begin
          speed_select_next = 2'(command_byte - CMD_SPEED_FIRST);
        end else if (command_byte == CMD_PLAY) begin
          play_flag_next = 1'b1;
        end else if (command_byte == CMD_PAUSE) begin
          if (play_flag) begin
            play_flag_next        = 1'b0;
            result.midscale_write = 1'b1;
          end
        end
      end
      REQ_REFRESH: begin
        result.frame_bits   = seq_frame(pattern_select, pos);
        result.frame_valid  = 1'b1;
        hold_count_next     = hc_inc;
        frame_position_next = pos;
        if (hc_inc >= hold) begin
          hold_count_next     = 8'd0;
          frame_position_next = (pos_plus >= cur_len) ? 3'd0 : pos_plus[2:0];
        end
      end
      REQ_SAMPLE: begin
        if (play_flag) begin
          sample_index        = buffer_position;
          result.sample_valid = 1'b1;
          buffer_position_next = buf_plus[IW-1:0];
          if (buf_plus == HALF_MARK) begin
            result.refill_request = 1'b1;
          end else if (buf_plus >= FULL_MARK) begin
            buffer_position_next  = '0;
            result.refill_request = 1'b1;
            result.refill_half    = 1'b1;
          end
        end
      end
      default: ;
    endcase

    result.playing_now = play_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_select  <= 3'd0;
      speed_select    <= SPEED_ONE;
      hold_count      <= 8'd0;
      frame_position  <= 3'd0;
      play_flag       <= 1'b0;
      buffer_position <= '0;
    end else if (fire) begin
      pattern_select  <= pattern_select_next;
      speed_select    <= speed_select_next;
      hold_count      <= hold_count_next;
      frame_position  <= frame_position_next;
      play_flag       <= play_flag_next;
      buffer_position <= buffer_position_next;
    end
  end

endmodule
